FILE: design/cbus_pkg.sv
// cbus_pkg: shared types and constants of the cubic bezier uniform sampler
// no dependencies; imported by every module of the block

package cbus_pkg;

  // default values of the top-level parameters
  localparam int COORD_WIDTH_DEF  = 16;
  localparam int MAX_SEGMENTS_DEF = 63;
  localparam int T_FRAC_BITS_DEF  = 16;

  // fixed field widths
  localparam int IDX_W    = 6;   // segment count, sample index
  localparam int NUM_CTRL = 12;  // four points, three coordinates each

  // segment count after reset
  localparam logic [IDX_W-1:0] NUM_SEG_RESET = IDX_W'(16);

  // status handed from the step divider to the sample engine
  typedef struct packed {
    logic             done;  // step values below are valid
    logic [IDX_W-1:0] n;     // effective segment count
    logic [IDX_W-1:0] rem;   // (2^T) mod n
  } step_info_t;

endpackage

FILE: design/cubic_bezier_uniform_sampler.sv
// cubic_bezier_uniform_sampler: top level of the cubic bezier sampler
// depends on cbus_pkg, cbus_front, cbus_step, cbus_back
//
// usage:
//   s_axis carries one curve per transaction: twelve control coordinates,
//   p0_x in the lowest bits up to p3_z. m_axis returns segment count + 1
//   curve points per curve, in order of the sample index, tlast on the
//   point where t equals one. cfg writes the 6-bit segment count
//   (0 acts as 1, counts above MAX_SEGMENTS saturate); write it only while
//   no curve is in flight.
//   throughput: one point per cycle while m_axis is ready, paced by the
//   sample sequencer; queued curves follow each other without a gap.
//   the first point of a curve passes the input queue and then six
//   pipeline registers (stages one to five and the output register)
//   before it shows on m_axis. after reset and after each cfg write a curve
//   is started only once the step divider is done; input transactions are
//   still taken into the two-entry queue meanwhile.
//   when m_axis stalls, the whole evaluation pipeline holds and the queue
//   keeps taking input until it is full.

module cubic_bezier_uniform_sampler #(
  parameter int COORD_WIDTH  = cbus_pkg::COORD_WIDTH_DEF,
  parameter int MAX_SEGMENTS = cbus_pkg::MAX_SEGMENTS_DEF,
  parameter int T_FRAC_BITS  = cbus_pkg::T_FRAC_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // cfg: segment count
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [cbus_pkg::IDX_W-1:0] cfg_data_i,
  // tdata: p0_x p0_y p0_z p1_x p1_y p1_z p2_x p2_y p2_z p3_x p3_y p3_z, zero pad
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [((cbus_pkg::NUM_CTRL*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // tdata: pt_x pt_y pt_z sample_index, zero pad
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [((3*COORD_WIDTH+cbus_pkg::IDX_W+7)/8)*8-1:0] m_axis_tdata,
  output logic                       m_axis_tlast
);
  import cbus_pkg::*;

  localparam int DW    = NUM_CTRL * COORD_WIDTH;
  localparam int OUTW  = 3 * COORD_WIDTH + IDX_W;
  localparam int OPADW = ((OUTW + 7) / 8) * 8;

  step_info_t              info;
  logic [T_FRAC_BITS:0]    quo;
  logic                    head_valid;
  logic [DW-1:0]           head_data;
  logic                    pop;
  logic [COORD_WIDTH-1:0]  pt_x, pt_y, pt_z;
  logic [IDX_W-1:0]        idx;

  // input queue
  cbus_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_data_i    (s_axis_tdata[DW-1:0]),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_data_o  (head_data)
  );

  // segment count and parameter step
  cbus_step #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .T_FRAC_BITS  (T_FRAC_BITS)
  ) u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .info_o      (info),
    .quo_o       (quo)
  );

  // sample engine
  cbus_back #(
    .COORD_WIDTH (COORD_WIDTH),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .info_i       (info),
    .quo_i        (quo),
    .head_valid_i (head_valid),
    .head_data_i  (head_data),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .pt_x_o       (pt_x),
    .pt_y_o       (pt_y),
    .pt_z_o       (pt_z),
    .idx_o        (idx),
    .last_o       (m_axis_tlast)
  );

  // result packing
  assign m_axis_tdata = OPADW'({idx, pt_z, pt_y, pt_x});

endmodule

FILE: design/cbus_front.sv
// cbus_front: input side of the sampler, takes control point transactions
// into a two-entry queue; depends on cbus_pkg

module cbus_front #(
  parameter int COORD_WIDTH = cbus_pkg::COORD_WIDTH_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       in_valid_i,
  output logic                                       in_ready_o,
  input  logic [cbus_pkg::NUM_CTRL*COORD_WIDTH-1:0]  in_data_i,
  input  logic                                       pop_i,
  output logic                                       head_valid_o,
  output logic [cbus_pkg::NUM_CTRL*COORD_WIDTH-1:0]  head_data_o
);
  import cbus_pkg::*;

  localparam int DW = NUM_CTRL * COORD_WIDTH;

  logic [DW-1:0] mem_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;
  logic          push;
  logic          pop;

  assign in_ready_o   = (cnt_q != 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_data_o  = mem_q[rd_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = pop_i && head_valid_o;

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

FILE: design/cbus_step.sv
// cbus_step: segment count register and serial divider giving the parameter
// step 2^T / n and its remainder; depends on cbus_pkg

module cbus_step #(
  parameter int MAX_SEGMENTS = cbus_pkg::MAX_SEGMENTS_DEF,
  parameter int T_FRAC_BITS  = cbus_pkg::T_FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [cbus_pkg::IDX_W-1:0]  cfg_data_i,
  output cbus_pkg::step_info_t        info_o,
  output logic [T_FRAC_BITS:0]        quo_o
);
  import cbus_pkg::*;

  localparam int QW = T_FRAC_BITS + 1;
  localparam int CNTW = $clog2(QW + 1);

  logic [IDX_W-1:0] n_q;
  logic [IDX_W-1:0] rem_q, rem_d;
  logic [QW-1:0]    quo_q;
  logic [CNTW-1:0]  cnt_q;
  logic             busy_q;
  logic             cfg_wr;
  logic             bit_in;
  logic [IDX_W:0]   rem_sh;
  logic             ge;

  // zero maps to one, large counts saturate
  function automatic logic [IDX_W-1:0] clamp_n(input logic [IDX_W-1:0] v);
    logic [IDX_W-1:0] r;
    r = (v == '0) ? IDX_W'(1) : v;
    if (int'(r) > MAX_SEGMENTS) begin
      r = IDX_W'(MAX_SEGMENTS);
    end
    return r;
  endfunction

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i;

  // restoring division of 2^T: only the leading dividend bit is set
  assign bit_in = (cnt_q == CNTW'(QW));
  assign rem_sh = {rem_q, bit_in};
  assign ge     = (rem_sh >= {1'b0, n_q});
  assign rem_d  = ge ? IDX_W'(rem_sh - {1'b0, n_q}) : rem_sh[IDX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q    <= clamp_n(NUM_SEG_RESET);
      busy_q <= 1'b1;
      cnt_q  <= CNTW'(QW);
      rem_q  <= '0;
      quo_q  <= '0;
    end else if (cfg_wr) begin
      n_q    <= clamp_n(cfg_data_i);
      busy_q <= 1'b1;
      cnt_q  <= CNTW'(QW);
      rem_q  <= '0;
      quo_q  <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[QW-2:0], ge};
      cnt_q <= cnt_q - CNTW'(1);
      if (cnt_q == CNTW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign info_o.done = !busy_q;
  assign info_o.n    = n_q;
  assign info_o.rem  = rem_q;
  assign quo_o       = quo_q;

endmodule

FILE: design/cbus_back.sv
// cbus_back: sample sequencer and pipelined bernstein evaluation with the
// output register; depends on cbus_pkg

module cbus_back #(
  parameter int COORD_WIDTH = cbus_pkg::COORD_WIDTH_DEF,
  parameter int T_FRAC_BITS = cbus_pkg::T_FRAC_BITS_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  cbus_pkg::step_info_t                       info_i,
  input  logic [T_FRAC_BITS:0]                       quo_i,
  input  logic                                       head_valid_i,
  input  logic [cbus_pkg::NUM_CTRL*COORD_WIDTH-1:0]  head_data_i,
  output logic                                       pop_o,
  output logic                                       out_valid_o,
  input  logic                                       out_ready_i,
  output logic [COORD_WIDTH-1:0]                     pt_x_o,
  output logic [COORD_WIDTH-1:0]                     pt_y_o,
  output logic [COORD_WIDTH-1:0]                     pt_z_o,
  output logic [cbus_pkg::IDX_W-1:0]                 idx_o,
  output logic                                       last_o
);
  import cbus_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int T   = T_FRAC_BITS;
  localparam int TW  = T + 1;
  localparam int UW  = 2 * TW;
  localparam int XW  = 3 * TW;
  localparam int WW  = 3 * T + 1;
  localparam int PW  = CW + WW + 1;
  localparam int SW1 = PW + 1;
  localparam int SW2 = PW + 2;
  localparam logic [TW-1:0] ONE = {1'b1, {T{1'b0}}};
  localparam logic signed [SW1-1:0] RND =
    {{(SW1 - 3 * T){1'b0}}, 1'b1, {(3 * T - 1){1'b0}}};

  typedef logic [NUM_CTRL-1:0][CW-1:0] coords_t;

  // sequencer state
  logic             run_q;
  logic [IDX_W-1:0] i_q;
  logic [TW-1:0]    t_q;
  logic [IDX_W-1:0] r_q;
  coords_t          coord_q;

  logic             en, start, issue;
  logic [IDX_W-1:0] i_s, r_s, r_n;
  logic [TW-1:0]    t_s, t_n;
  coords_t          c_s;
  logic             last_s;
  logic [IDX_W:0]   rsum;
  logic             wrap;

  // pipeline registers
  logic             v1_q, v2_q, v3_q, v4_q, v5_q, vo_q;
  logic [IDX_W-1:0] i1_q, i2_q, i3_q, i4_q, i5_q, io_q;
  logic             l1_q, l2_q, l3_q, l4_q, l5_q, lo_q;
  coords_t          c1_q, c2_q, c3_q;
  logic [TW-1:0]    t1_q, u1_q, t2_q, u2_q;
  logic [UW-1:0]    uu2_q, tt2_q;
  logic [WW-1:0]    w3_q [4];
  logic signed [PW-1:0]  prod_d [NUM_CTRL];
  logic signed [PW-1:0]  prod4_q [NUM_CTRL];
  logic signed [SW1-1:0] pair_d [6];
  logic signed [SW1-1:0] pair5_q [6];
  logic signed [SW2-1:0] total [3];
  logic [CW-1:0]         pt_q [3];
  logic [XW-1:0]         uut, ttu, uuu, ttt;

  assign en    = !vo_q || out_ready_i;
  assign start = !run_q && head_valid_i && info_i.done;
  assign issue = en && (run_q || start);
  assign pop_o = en && start;

  // current sample and the incremental step to the next one
  assign t_s    = run_q ? t_q : '0;
  assign r_s    = run_q ? r_q : '0;
  assign i_s    = run_q ? i_q : '0;
  assign c_s    = run_q ? coord_q : head_data_i;
  assign last_s = (i_s == info_i.n);
  assign rsum   = {1'b0, r_s} + {1'b0, info_i.rem};
  assign wrap   = (rsum >= {1'b0, info_i.n});
  assign r_n    = wrap ? IDX_W'(rsum - {1'b0, info_i.n}) : rsum[IDX_W-1:0];
  assign t_n    = t_s + quo_i + TW'(wrap);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      i_q   <= '0;
      t_q   <= '0;
      r_q   <= '0;
    end else if (issue) begin
      run_q <= !last_s;
      i_q   <= i_s + IDX_W'(1);
      t_q   <= t_n;
      r_q   <= r_n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      coord_q <= c_s;
    end
  end

  // valid bits of the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      v1_q <= run_q || start;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      vo_q <= v5_q;
    end
  end

  // weight products
  assign uuu = XW'(uu2_q) * XW'(u2_q);
  assign uut = XW'(uu2_q) * XW'(t2_q);
  assign ttu = XW'(tt2_q) * XW'(u2_q);
  assign ttt = XW'(tt2_q) * XW'(t2_q);

  // coordinate times weight, signed by unsigned
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[k * 3 + c] = PW'($signed(c3_q[k * 3 + c])) *
                            PW'($signed({1'b0, w3_q[k]}));
      end
    end
  end

  // pairwise sums, rounding constant folded into the first pair
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      pair_d[2 * c]     = SW1'(prod4_q[c]) + SW1'(prod4_q[3 + c]) + RND;
      pair_d[2 * c + 1] = SW1'(prod4_q[6 + c]) + SW1'(prod4_q[9 + c]);
    end
  end

  // final sum, scaled by the bit slice taken in the output register
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      total[c] = SW2'(pair5_q[2 * c]) + SW2'(pair5_q[2 * c + 1]);
    end
  end

  // datapath stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      // stage 1: parameter and complement
      t1_q <= t_s;
      u1_q <= ONE - t_s;
      i1_q <= i_s;
      l1_q <= last_s;
      c1_q <= c_s;
      // stage 2: squares
      uu2_q <= UW'(u1_q) * UW'(u1_q);
      tt2_q <= UW'(t1_q) * UW'(t1_q);
      t2_q  <= t1_q;
      u2_q  <= u1_q;
      i2_q  <= i1_q;
      l2_q  <= l1_q;
      c2_q  <= c1_q;
      // stage 3: bernstein weights
      w3_q[0] <= WW'(uuu);
      w3_q[1] <= WW'(uut + {uut[XW-2:0], 1'b0});
      w3_q[2] <= WW'(ttu + {ttu[XW-2:0], 1'b0});
      w3_q[3] <= WW'(ttt);
      i3_q    <= i2_q;
      l3_q    <= l2_q;
      c3_q    <= c2_q;
      // stage 4: products
      for (int j = 0; j < NUM_CTRL; j++) begin
        prod4_q[j] <= prod_d[j];
      end
      i4_q <= i3_q;
      l4_q <= l3_q;
      // stage 5: pair sums
      for (int j = 0; j < 6; j++) begin
        pair5_q[j] <= pair_d[j];
      end
      i5_q <= i4_q;
      l5_q <= l4_q;
      // output register
      for (int c = 0; c < 3; c++) begin
        pt_q[c] <= total[c][3 * T +: CW];
      end
      io_q <= i5_q;
      lo_q <= l5_q;
    end
  end

  assign out_valid_o = vo_q;
  assign pt_x_o      = pt_q[0];
  assign pt_y_o      = pt_q[1];
  assign pt_z_o      = pt_q[2];
  assign idx_o       = io_q;
  assign last_o      = lo_q;

endmodule
